// ----- rtl/core/tcw_pkg.sv -----
// Shared constants and control types of the text console writer.
`default_nettype none
package tcw_pkg;

   // Field widths
   localparam int OP_W   = 2;
   localparam int CH_W   = 8;
   localparam int ROW_FW = 5;
   localparam int COL_FW = 7;
   localparam int CELL_W = 16;
   localparam int ATTR_W = 8;

   // Default screen geometry
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // Cell and character constants
   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
   localparam logic [CH_W-1:0]   NEWLINE_CH = 8'd10;
   localparam logic [CH_W-1:0]   RETURN_CH  = 8'd13;
   localparam logic [CH_W-1:0]   SPACE_CH   = 8'h20;

   // Command to the sweep engine
   typedef struct packed {
      logic              start;
      logic              scroll;
      logic [CELL_W-1:0] fill_val;
   } sweep_cmd_type;

   // Status from the sweep engine
   typedef struct packed {
      logic busy;
      logic done;
   } sweep_stat_type;

endpackage
`default_nettype wire

// ----- rtl/core/tcw_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule
`default_nettype wire

// ----- rtl/core/tcw_sweep.sv -----
// Sweep engine: scroll copy and fill passes over the screen RAM.
`default_nettype none
module tcw_sweep #(
   parameter int CELLS   = 2000,
   parameter int COLUMNS = 80
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire tcw_pkg::sweep_cmd_type         cmd,
   output      tcw_pkg::sweep_stat_type        stat,
   output      logic [$clog2(CELLS)-1:0]       raddr,
   input  wire logic [tcw_pkg::CELL_W-1:0]     rdata,
   output      logic                           we,
   output      logic [$clog2(CELLS)-1:0]       waddr,
   output      logic [tcw_pkg::CELL_W-1:0]     wdata
);
   import tcw_pkg::*;

   localparam int ADDR_W = $clog2(CELLS);
   localparam logic [ADDR_W-1:0] KEEP = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] OFFS = ADDR_W'(COLUMNS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_COPY = 3'b010,
      ST_FILL = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [CELL_W-1:0] fill_ff, fill_in;
   logic              cp_pend_ff, cp_pend_in;
   logic [ADDR_W-1:0] cp_addr_ff;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      fill_in    = fill_ff;
      cp_pend_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               fill_in  = cmd.fill_val;
               cnt_in   = '0;
               state_in = cmd.scroll ? ST_COPY : ST_FILL;
            end
         end
         ST_COPY: begin
            // one extra step at the end drains the last pending copy write
            if (cnt_ff == KEEP) begin
               state_in = ST_FILL;
            end else begin
               cp_pend_in = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
            end
         end
         ST_FILL: begin
            if (cnt_ff == LAST) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         cnt_ff     <= '0;
         fill_ff    <= BLANK_CELL;
         cp_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         fill_ff    <= fill_in;
         cp_pend_ff <= cp_pend_in;
      end
      cp_addr_ff <= cnt_ff;
   end

   assign raddr     = cnt_ff + OFFS;
   assign we        = cp_pend_ff || (state_ff == ST_FILL);
   assign waddr     = cp_pend_ff ? cp_addr_ff : cnt_ff;
   assign wdata     = cp_pend_ff ? rdata : fill_ff;
   assign stat.busy = (state_ff != ST_IDLE);
   assign stat.done = (state_ff == ST_FILL) && (cnt_ff == LAST);

endmodule
`default_nettype wire

// ----- rtl/core/text_console_writer.sv -----
// Top level of the text console writer: request decode, cursor and result register.
//
// Text-mode console over a ROWS x COLUMNS screen RAM of 16-bit cells (attribute
// in bits 15..8, character in bits 7..0). A put beat writes a byte other than
// newline or carriage return at the cursor and advances it; those two move the
// cursor; moving past the last row scrolls the screen up one row and blanks the
// bottom row in the csr attribute. A clear beat blanks every cell to 0x0F20 and
// homes the cursor; a read beat returns one cell. Every request beat gives one
// response beat. A scroll or clear runs as a sweep through the single write port
// of the screen RAM, which the sweep engine drives one cell per cycle. After
// reset the block runs a clearing pass over every cell before it takes the first
// request beat. The csr attribute may be written at any time the block is idle.
`default_nettype none
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic [tcw_pkg::OP_W-1:0]   req_op,
   input  wire logic [tcw_pkg::CH_W-1:0]   req_ch,
   input  wire logic [tcw_pkg::ROW_FW-1:0] req_read_row,
   input  wire logic [tcw_pkg::COL_FW-1:0] req_read_col,
   // response channel
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic [tcw_pkg::CELL_W-1:0] rsp_cell_data,
   output      logic [tcw_pkg::COL_FW-1:0] rsp_cursor_col,
   output      logic [tcw_pkg::ROW_FW-1:0] rsp_cursor_row,
   output      logic                       rsp_scrolled,
   // csr port
   input  wire logic                       csr_we,
   input  wire logic [tcw_pkg::ATTR_W-1:0] csr_wdata
);
   import tcw_pkg::*;

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam logic [COL_W:0]    COL_LIMIT = (COL_W + 1)'(COLUMNS);
   localparam logic [ROW_W:0]    ROW_LIMIT = (ROW_W + 1)'(ROWS);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(COLUMNS);

   // csr and cursor state
   logic [ATTR_W-1:0] attr_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   // response register and pending flags
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_data_ff, rsp_data_in;
   logic [COL_FW-1:0] rsp_col_ff, rsp_col_in;
   logic [ROW_FW-1:0] rsp_row_ff, rsp_row_in;
   logic              rsp_scr_ff, rsp_scr_in;
   logic              rd_pend_ff;
   logic              rd_oob_ff, rd_oob_in;
   logic              sw_pend_ff, sw_pend_in;
   logic              scr_pend_ff, scr_pend_in;

   // decode of the accepted beat
   logic              accept;
   logic              put_we;
   logic              scroll_go;
   logic              clear_go;
   logic              read_go;
   logic              imm_rsp;
   logic [COL_W:0]    col_inc;
   logic [ROW_W:0]    row_inc;
   logic [ADDR_W-1:0] put_addr;
   logic [ADDR_W-1:0] rd_addr;

   // RAM and sweep hookup
   sweep_cmd_type     sw_cmd;
   sweep_stat_type    sw_stat;
   logic [ADDR_W-1:0] sw_raddr, sw_waddr;
   logic              sw_we;
   logic [CELL_W-1:0] sw_wdata;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;

   // Hold off new beats during a sweep, a pending read or a pending sweep result,
   // and while the response slot stays full.
   assign req_ready = !sw_stat.busy && !rd_pend_ff && !sw_pend_ff &&
                      (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign col_inc  = {1'b0, col_ff} + 1'b1;
   assign row_inc  = {1'b0, row_ff} + 1'b1;
   assign put_addr = ADDR_W'(row_ff) * ROW_PITCH + ADDR_W'(col_ff);
   assign rd_addr  = ADDR_W'(req_read_row) * ROW_PITCH + ADDR_W'(req_read_col);

   // Decode the request and work out the cursor after it.
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      put_we    = 1'b0;
      scroll_go = 1'b0;
      clear_go  = 1'b0;
      read_go   = 1'b0;
      rd_oob_in = 1'b0;
      imm_rsp   = 1'b0;
      if (accept) begin
         unique case (req_op)
            OP_PUT: begin
               if (req_ch == RETURN_CH) begin
                  col_in  = '0;
                  imm_rsp = 1'b1;
               end else begin
                  put_we = (req_ch != NEWLINE_CH);
                  if ((req_ch == NEWLINE_CH) || (col_inc >= COL_LIMIT)) begin
                     // advance to the next line, scroll past the last row
                     col_in = '0;
                     if (row_inc >= ROW_LIMIT) begin
                        row_in    = ROW_LAST;
                        scroll_go = 1'b1;
                     end else begin
                        row_in  = row_inc[ROW_W-1:0];
                        imm_rsp = 1'b1;
                     end
                  end else begin
                     col_in  = col_inc[COL_W-1:0];
                     imm_rsp = 1'b1;
                  end
               end
            end
            OP_CLEAR: begin
               col_in   = '0;
               row_in   = '0;
               clear_go = 1'b1;
            end
            OP_READ: begin
               read_go   = 1'b1;
               rd_oob_in = (int'(req_read_row) >= ROWS) || (int'(req_read_col) >= COLUMNS);
            end
            default: imm_rsp = 1'b1;
         endcase
      end
   end

   // Start a scroll or clear sweep; the scroll blank uses the current attribute.
   assign sw_cmd.start    = scroll_go || clear_go;
   assign sw_cmd.scroll   = scroll_go;
   assign sw_cmd.fill_val = clear_go ? BLANK_CELL : {attr_ff, SPACE_CH};

   assign sw_pend_in  = sw_cmd.start || (sw_pend_ff && !sw_stat.done);
   assign scr_pend_in = scroll_go ? 1'b1 : (clear_go ? 1'b0 : scr_pend_ff);

   // Load the response slot from whichever source finishes this cycle.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_scr_in   = rsp_scr_ff;
      priority if (rd_pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rd_oob_ff ? '0 : ram_rdata;
         rsp_col_in   = COL_FW'(col_ff);
         rsp_row_in   = ROW_FW'(row_ff);
         rsp_scr_in   = 1'b0;
      end else if (sw_pend_ff && sw_stat.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_col_in   = COL_FW'(col_ff);
         rsp_row_in   = ROW_FW'(row_ff);
         rsp_scr_in   = scr_pend_ff;
      end else if (imm_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_col_in   = COL_FW'(col_in);
         rsp_row_in   = ROW_FW'(row_in);
         rsp_scr_in   = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= ATTR_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         sw_pend_ff   <= 1'b0;
         scr_pend_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            attr_ff <= csr_wdata;
         end
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= read_go;
         sw_pend_ff   <= sw_pend_in;
         scr_pend_ff  <= scr_pend_in;
      end
      rd_oob_ff   <= rd_oob_in;
      rsp_data_ff <= rsp_data_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

   // The sweep engine owns the RAM while busy; a put writes at accept otherwise.
   assign ram_we    = sw_stat.busy ? sw_we : put_we;
   assign ram_waddr = sw_stat.busy ? sw_waddr : put_addr;
   assign ram_wdata = sw_stat.busy ? sw_wdata : {attr_ff, req_ch};
   assign ram_raddr = sw_stat.busy ? sw_raddr : rd_addr;

   tcw_sweep #(
      .CELLS   (CELLS),
      .COLUMNS (COLUMNS)
   ) u_sweep (
      .clock (clock),
      .reset (reset),
      .cmd   (sw_cmd),
      .stat  (sw_stat),
      .raddr (sw_raddr),
      .rdata (ram_rdata),
      .we    (sw_we),
      .waddr (sw_waddr),
      .wdata (sw_wdata)
   );

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .raddr    (ram_raddr),
      .rdata_ff (ram_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_data  = rsp_data_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_scrolled   = rsp_scr_ff;

endmodule
`default_nettype wire

// ----- tb/text_console_writer_tb.sv -----
// Self-checking testbench for the text console writer: text, scroll, clear and read beats.
`timescale 1ns / 1ps
module text_console_writer_tb;
   import tcw_pkg::*;

   localparam int COLS = DEF_COLUMNS;
   localparam int ROWS = DEF_ROWS;

   // The fourth op code does nothing but report the cursor.
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   // Cap on sweeps (scrolls plus clears); each one walks the whole screen RAM.
   localparam int SWEEP_BUDGET = 250;

   // Cycles with no beat on either channel before the run is called hung.
   // Covers the clearing pass after reset, a full sweep and a long receiver stall.
   localparam int WATCHDOG_LIMIT = 20000;

   // Cap on mismatch reports so a broken build cannot flood the log.
   localparam int REPORT_CAP = 100;

   typedef struct packed {
      logic [CELL_W-1:0] cell_data;
      logic [COL_FW-1:0] cursor_col;
      logic [ROW_FW-1:0] cursor_row;
      logic              scrolled;
   } console_result_type;

   // Shadow copy of the screen, cursor and attribute; predicts each response beat.
   class screen_shadow;
      logic [CELL_W-1:0]  cells [ROWS*COLS];
      int                 col;
      int                 row;
      logic [ATTR_W-1:0]  attr;
      int                 sweeps;
      int                 errors;
      console_result_type pending_results [$];

      function new();
         blank_screen();
         col    = 0;
         row    = 0;
         attr   = ATTR_RESET;
         sweeps = 0;
         errors = 0;
      endfunction

      function void blank_screen();
         foreach (cells[i]) cells[i] = BLANK_CELL;
      endfunction

      function void set_attribute(logic [ATTR_W-1:0] value);
         attr = value;
      endfunction

      // Move to column 0 of the next row; scroll up and blank the bottom row
      // in the current attribute when the cursor falls off the screen.
      function bit line_feed();
         col = 0;
         row++;
         if (row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLS; i++) cells[i] = cells[i + COLS];
            for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++) cells[i] = {attr, SPACE_CH};
            row = ROWS - 1;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void take_request(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                                 logic [ROW_FW-1:0] rr, logic [COL_FW-1:0] rc);
         console_result_type r;
         r = '0;
         case (op)
            OP_PUT: begin
               if (ch == NEWLINE_CH) begin
                  r.scrolled = line_feed();
               end else if (ch == RETURN_CH) begin
                  col = 0;
               end else begin
                  cells[row * COLS + col] = {attr, ch};
                  col++;
                  if (col >= COLS) r.scrolled = line_feed();
               end
            end
            OP_CLEAR: begin
               blank_screen();
               col = 0;
               row = 0;
            end
            OP_READ: begin
               if (rr < ROWS && rc < COLS) r.cell_data = cells[rr * COLS + rc];
            end
            default: ;
         endcase
         if (r.scrolled || op == OP_CLEAR) sweeps++;
         r.cursor_col = COL_FW'(col);
         r.cursor_row = ROW_FW'(row);
         pending_results.push_back(r);
      endfunction

      function void report(string field, longint unsigned exp_v, longint unsigned got_v);
         errors++;
         if (errors <= REPORT_CAP) $error("%s: expected %0h, got %0h", field, exp_v, got_v);
      endfunction

      function void match_response(console_result_type got);
         console_result_type exp_r;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP) $error("response beat with no request outstanding");
            return;
         end
         exp_r = pending_results.pop_front();
         if (got.cell_data !== exp_r.cell_data)
            report("cell_data", exp_r.cell_data, got.cell_data);
         if (got.cursor_col !== exp_r.cursor_col)
            report("cursor_col", exp_r.cursor_col, got.cursor_col);
         if (got.cursor_row !== exp_r.cursor_row)
            report("cursor_row", exp_r.cursor_row, got.cursor_row);
         if (got.scrolled !== exp_r.scrolled)
            report("scrolled", exp_r.scrolled, got.scrolled);
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [OP_W-1:0]   req_op;
   logic [CH_W-1:0]   req_ch;
   logic [ROW_FW-1:0] req_read_row;
   logic [COL_FW-1:0] req_read_col;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CELL_W-1:0] rsp_cell_data;
   logic [COL_FW-1:0] rsp_cursor_col;
   logic [ROW_FW-1:0] rsp_cursor_row;
   logic              rsp_scrolled;
   logic              csr_we;
   logic [ATTR_W-1:0] csr_wdata;

   screen_shadow shadow;
   int           beats_sent;
   int           burst_left;
   int           idle_cycles;
   logic [15:0]  ready_pattern;
   int           pattern_age;

   text_console_writer #(
      .COLUMNS(COLS),
      .ROWS(ROWS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_ch(req_ch),
      .req_read_row(req_read_row),
      .req_read_col(req_read_col),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cell_data(rsp_cell_data),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_scrolled(rsp_scrolled),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: rotate a 16-bit ready pattern and, when its age counter runs out, swap it
   // for one of always ready, random stalls or heavy stalls.
   always @(posedge clock) begin : receiver_pacing
      int unsigned mode;
      if (reset) begin
         ready_pattern <= 16'hFFFF;
         pattern_age   <= 0;
      end else if (pattern_age == 0) begin
         mode = $urandom_range(0, 2);
         ready_pattern <= (mode == 0) ? 16'hFFFF :
                          (mode == 1) ? 16'($urandom) : 16'($urandom & $urandom);
         pattern_age   <= 64;
      end else begin
         ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
         pattern_age   <= pattern_age - 1;
      end
      rsp_ready <= reset ? 1'b0 : ready_pattern[15];
   end

   // Check each response beat and watch for a hung block. Values read here are
   // the ones that stood before this edge, so beats line up with the RTL's view.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            shadow.match_response({rsp_cell_data, rsp_cursor_col, rsp_cursor_row,
                                   rsp_scrolled});
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Drive one request beat and hold it until accepted, then note it in the
   // shadow. Between bursts, drop valid for a random gap, or not at all.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                            input logic [ROW_FW-1:0] rr, input logic [COL_FW-1:0] rc);
      int gap;
      req_valid    <= 1'b1;
      req_op       <= op;
      req_ch       <= ch;
      req_read_row <= rr;
      req_read_col <= rc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shadow.take_request(op, ch, rr, rc);
      beats_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Put a character; the read fields are don't-care, so fill them with noise.
   task automatic send_put(input logic [CH_W-1:0] ch);
      send_item(OP_PUT, ch, ROW_FW'($urandom), COL_FW'($urandom));
   endtask

   // Hold off the sender until every outstanding response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (shadow.pending_results.size() != 0) @(posedge clock);
   endtask

   // Write the attribute register; only called with the block idle.
   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      drain_responses();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      shadow.set_attribute(value);
      csr_we    <= 1'b0;
   endtask

   // Mostly lines of text (short, exactly one row, or wrapping) ending in
   // newline, return, both or neither, with read-backs near the cursor, newline runs
   // that push into scrolling, the odd clear, and random noise beats.
   task automatic run_text_phase(input int quota);
      int              first;
      int              len;
      int              pick;
      int              k;
      logic [CH_W-1:0] glyph;
      logic [OP_W-1:0] op;
      int              rr;
      first = beats_sent;
      while (beats_sent - first < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            k = $urandom_range(0, 9);
            len = (k == 0) ? COLS :
                  (k == 1) ? $urandom_range(COLS + 1, 2 * COLS) : $urandom_range(0, 30);
            for (int i = 0; i < len; i++) begin
               do glyph = CH_W'($urandom); while (glyph == NEWLINE_CH || glyph == RETURN_CH);
               send_put(glyph);
            end
            k = $urandom_range(0, 9);
            if (k < 6) begin
               send_put(NEWLINE_CH);
            end else if (k < 8) begin
               send_put(RETURN_CH);
               send_put(NEWLINE_CH);
            end else if (k == 8) begin
               send_put(RETURN_CH);
            end
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 4)) begin
               k = $urandom_range(0, 3);
               rr = (k == 0) ? $urandom_range(0, ROWS - 1) :
                    (k == 1 && shadow.row > 0) ? shadow.row - 1 : shadow.row;
               send_item(OP_READ, CH_W'($urandom), ROW_FW'(rr),
                         COL_FW'($urandom_range(0, COLS - 1)));
            end
         end else if (pick < 91) begin
            if (shadow.sweeps < SWEEP_BUDGET)
               repeat ($urandom_range(1, 30)) send_put(NEWLINE_CH);
         end else if (pick < 93) begin
            if (shadow.sweeps < SWEEP_BUDGET)
               send_item(OP_CLEAR, CH_W'($urandom), ROW_FW'($urandom), COL_FW'($urandom));
         end else begin
            op = OP_W'($urandom);
            if (op == OP_CLEAR && shadow.sweeps >= SWEEP_BUDGET) op = OP_READ;
            send_item(op, CH_W'($urandom), ROW_FW'($urandom), COL_FW'($urandom));
         end
      end
   endtask

   initial begin
      shadow       = new();
      beats_sent   = 0;
      burst_left   = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op       = OP_PUT;
      req_ch       = '0;
      req_read_row = '0;
      req_read_col = '0;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset contents, byte zero and high bytes in the reset
      // attribute, return, newline, the unused op, reads at and past the edges.
      send_item(OP_READ, '0, '0, '0);
      send_put(8'h00);
      send_put(8'hFF);
      send_put(8'h80);
      send_put(8'h7F);
      send_item(OP_READ, 8'hFF, 5'd0, 7'd0);
      send_item(OP_READ, 8'h00, 5'd0, 7'd3);
      send_put(RETURN_CH);
      send_item(OP_READ, '0, 5'd0, 7'd1);
      send_put(NEWLINE_CH);
      send_item(OP_PUT, 8'h41, '1, '1);
      send_item(OP_NONE, '1, '1, '1);
      send_item(OP_READ, '0, '1, '1);
      send_item(OP_READ, '0, 5'(ROWS), 7'd0);
      send_item(OP_READ, '0, 5'd0, 7'(COLS));
      send_item(OP_READ, '0, 5'(ROWS - 1), 7'(COLS - 1));
      send_item(OP_READ, '0, 5'd1, 7'd0);
      send_item(OP_CLEAR, '1, '1, '1);
      send_item(OP_READ, '0, 5'd0, 7'd0);
      send_item(OP_READ, '0, 5'd1, 7'd0);

      // Random phases, each under its own attribute, extremes first.
      write_attribute(8'hFF);
      run_text_phase(205);
      write_attribute(8'h00);
      run_text_phase(205);
      write_attribute(ATTR_W'($urandom));
      run_text_phase(205);
      write_attribute(8'h5A);
      run_text_phase(205);

      // Let the tail drain, then give stray beats a chance to show up.
      drain_responses();
      repeat (20) @(posedge clock);
      if (shadow.errors == 0 && shadow.pending_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
